// ===== rtl/core/window_layer_pixel_compositor_core_defines.svh =====
// Assertion helpers for the checker file.
`ifndef WINDOW_LAYER_PIXEL_COMPOSITOR_CORE_DEFINES_SVH
`define WINDOW_LAYER_PIXEL_COMPOSITOR_CORE_DEFINES_SVH

// Clocked assertion, masked while reset is asserted.
`define WLPC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define WLPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/wlpc_pkg.sv =====
`default_nettype none

package wlpc_pkg;

	localparam int WLPC_SCREEN_W = 240;
	localparam int WLPC_SCREEN_H = 160;

	localparam logic [15:0] TRANSPARENT_COLOR = 16'hFFFF;

	// register map, one 32-bit word per register
	typedef enum logic [2:0] {
		REG_DISPLAY_CONTROL = 3'd0,
		REG_WIN_INSIDE_SEL  = 3'd1,
		REG_WIN_OUTSIDE_SEL = 3'd2,
		REG_WIN0_H          = 3'd3,
		REG_WIN1_H          = 3'd4,
		REG_WIN0_V          = 3'd5,
		REG_WIN1_V          = 3'd6,
		REG_BACKDROP        = 3'd7
	} wlpc_reg_t;

	// display control register bit positions
	localparam int DC_BG0_EN = 8;
	localparam int DC_OBJ_EN = 12;
	localparam int DC_WIN0   = 13;
	localparam int DC_WIN1   = 14;
	localparam int DC_WINOBJ = 15;

	// window setup handed to the window tracker
	typedef struct packed {
		logic        w0_on;
		logic        w1_on;
		logic        wo_on;
		logic [15:0] inside_sel;
		logic [15:0] outside_sel;
		logic [15:0] w0_h;
		logic [15:0] w1_h;
		logic [15:0] w0_v;
		logic [15:0] w1_v;
	} wlpc_win_cfg_t;

	// set on the start bound, clear on the end bound (end wins if equal)
	function automatic logic track_bound(input logic flag, input logic [7:0] coord,
		input logic [15:0] bounds);
		logic f;
		f = flag;
		if (coord == bounds[15:8]) f = 1'b1;
		if (coord == bounds[7:0]) f = 1'b0;
		return f;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wlpc_window.sv =====
`default_nettype none

module wlpc_window
	import wlpc_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire wlpc_win_cfg_t cfg,
	input  wire logic          advance,
	input  wire logic [7:0]    pixel_x,
	input  wire logic [7:0]    pixel_y,
	input  wire logic          sprite_opaque,
	output      logic [4:0]    layer_en
);

	logic w0_h_q, w0_v_q, w1_h_q, w1_v_q;
	logic w0_h_d, w0_v_d, w1_h_d, w1_v_d;
	logic any_on;

	assign any_on = cfg.w0_on | cfg.w1_on | cfg.wo_on;

	always_comb begin
		w0_h_d = track_bound(w0_h_q, pixel_x, cfg.w0_h);
		w0_v_d = track_bound(w0_v_q, pixel_y, cfg.w0_v);
		w1_h_d = track_bound(w1_h_q, pixel_x, cfg.w1_h);
		w1_v_d = track_bound(w1_v_q, pixel_y, cfg.w1_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_h_q <= 1'b0;
			w0_v_q <= 1'b0;
			w1_h_q <= 1'b0;
			w1_v_q <= 1'b0;
		end else if (advance && any_on) begin
			w0_h_q <= w0_h_d;
			w0_v_q <= w0_v_d;
			w1_h_q <= w1_h_d;
			w1_v_q <= w1_v_d;
		end
	end

	// later rule wins: outside, object window, window1, window0
	always_comb begin
		if (!any_on) begin
			layer_en = 5'h1F;
		end else if (cfg.w0_on && w0_h_d && w0_v_d) begin
			layer_en = cfg.inside_sel[4:0];
		end else if (cfg.w1_on && w1_h_d && w1_v_d) begin
			layer_en = cfg.inside_sel[12:8];
		end else if (cfg.wo_on && sprite_opaque) begin
			layer_en = cfg.outside_sel[12:8];
		end else begin
			layer_en = cfg.outside_sel[4:0];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/window_layer_pixel_compositor_core.sv =====
// Window and layer pixel compositor.
// Input stream (s_*): one beat per screen pixel in raster order, carrying the
// coordinates, a sprite colour and four background colours (0xFFFF is
// transparent). Output stream (m_*): one beat per input beat, the chosen
// colour split into 5-bit red, green and blue, in input order.
// Registers are to be written over the APB port only while no pixel is in
// flight; the block itself does not enforce this. From input beat to output
// beat there is an input register, then window tracking and layer selection
// feeding the output register. Throughput is one pixel per cycle while the
// receiver takes beats; the window flags are the only state carried from
// pixel to pixel and they update in the same cycle. When the receiver stalls,
// the output register holds its beat and the input register can still take
// one more beat; s_tready drops only when both are full and m_tready is low.
// Reset clears all registers, the window flags and both valid bits.
`default_nettype none

module window_layer_pixel_compositor_core
	import wlpc_pkg::*;
#(
	parameter int SCREEN_W = WLPC_SCREEN_W,
	parameter int SCREEN_H = WLPC_SCREEN_H
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready,
	// pixel in
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	// pixel_x, pixel_y, spr_color, bg0_color, bg1_color, bg2_color, bg3_color
	input  wire logic [95:0] s_tdata,
	// colour out
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	// red, green, blue, one zero pad bit
	output      logic [15:0] m_tdata
);

	localparam logic [8:0] SCR_W = 9'(SCREEN_W);
	localparam logic [8:0] SCR_H = 9'(SCREEN_H);

	logic [15:0] dispcnt_q, win_in_q, win_out_q, w0h_q, w1h_q, w0v_q, w1v_q, backdrop_q;

	logic        wr_en;
	wlpc_reg_t   reg_sel;
	logic [15:0] rd_data;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = wlpc_reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dispcnt_q  <= '0;
			win_in_q   <= '0;
			win_out_q  <= '0;
			w0h_q      <= '0;
			w1h_q      <= '0;
			w0v_q      <= '0;
			w1v_q      <= '0;
			backdrop_q <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_DISPLAY_CONTROL: dispcnt_q  <= pwdata[15:0];
				REG_WIN_INSIDE_SEL:  win_in_q   <= pwdata[15:0];
				REG_WIN_OUTSIDE_SEL: win_out_q  <= pwdata[15:0];
				REG_WIN0_H:          w0h_q      <= pwdata[15:0];
				REG_WIN1_H:          w1h_q      <= pwdata[15:0];
				REG_WIN0_V:          w0v_q      <= pwdata[15:0];
				REG_WIN1_V:          w1v_q      <= pwdata[15:0];
				REG_BACKDROP:        backdrop_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_DISPLAY_CONTROL: rd_data = dispcnt_q;
			REG_WIN_INSIDE_SEL:  rd_data = win_in_q;
			REG_WIN_OUTSIDE_SEL: rd_data = win_out_q;
			REG_WIN0_H:          rd_data = w0h_q;
			REG_WIN1_H:          rd_data = w1h_q;
			REG_WIN0_V:          rd_data = w0v_q;
			REG_WIN1_V:          rd_data = w1v_q;
			REG_BACKDROP:        rd_data = backdrop_q;
			default:             rd_data = '0;
		endcase
	end

	assign prdata = {16'h0000, rd_data};

	// input register
	logic        valid_s1;
	logic [7:0]  x_s1, y_s1;
	logic [15:0] color_s1 [5];
	logic        m_valid_q;
	logic [14:0] color_q;
	logic        adv_s1;

	assign adv_s1   = !m_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			x_s1        <= s_tdata[7:0];
			y_s1        <= s_tdata[15:8];
			color_s1[0] <= s_tdata[31:16];
			color_s1[1] <= s_tdata[47:32];
			color_s1[2] <= s_tdata[63:48];
			color_s1[3] <= s_tdata[79:64];
			color_s1[4] <= s_tdata[95:80];
		end
	end

	// layer selection
	logic          on_screen;
	logic [4:0]    opaque;
	logic [4:0]    layer_en;
	logic [14:0]   color_d;
	wlpc_win_cfg_t win_cfg;

	assign on_screen = ({1'b0, x_s1} < SCR_W) && ({1'b0, y_s1} < SCR_H);

	always_comb begin
		for (int i = 0; i < 5; i++) begin
			opaque[i] = on_screen && (color_s1[i] != TRANSPARENT_COLOR);
		end
	end

	always_comb begin
		win_cfg.w0_on       = dispcnt_q[DC_WIN0];
		win_cfg.w1_on       = dispcnt_q[DC_WIN1];
		win_cfg.wo_on       = dispcnt_q[DC_WINOBJ];
		win_cfg.inside_sel  = win_in_q;
		win_cfg.outside_sel = win_out_q;
		win_cfg.w0_h        = w0h_q;
		win_cfg.w1_h        = w1h_q;
		win_cfg.w0_v        = w0v_q;
		win_cfg.w1_v        = w1v_q;
	end

	wlpc_window u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (win_cfg),
		.advance       (valid_s1 && adv_s1),
		.pixel_x       (x_s1),
		.pixel_y       (y_s1),
		.sprite_opaque (opaque[0]),
		.layer_en      (layer_en)
	);

	always_comb begin
		color_d = backdrop_q[14:0];
		if (opaque[0] && dispcnt_q[DC_OBJ_EN] && layer_en[4]) begin
			color_d = color_s1[0][14:0];
		end else begin
			// lowest numbered shown background wins
			for (int i = 3; i >= 0; i--) begin
				if (opaque[i+1] && dispcnt_q[DC_BG0_EN+i] && layer_en[i]) begin
					color_d = color_s1[i+1][14:0];
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv_s1) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			color_q <= color_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, color_q};

endmodule

`default_nettype wire

// ===== rtl/core/wlpc_checker.sv =====
`default_nettype none
`include "window_layer_pixel_compositor_core_defines.svh"

module wlpc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);

	`WLPC_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output beat changed while stalled")
	`WLPC_ASSERT(a_stall_only_full, clk, arst_n, !s_tready |-> m_tvalid && !m_tready, "input stalled while output can drain")
	`WLPC_ASSERT(a_two_cycle_path, clk, arst_n, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2), "output beat without input beat two cycles earlier")
	`WLPC_ASSERT(a_pad_zero, clk, arst_n, m_tvalid |-> !m_tdata[15], "pad bit of output beat set")
	`WLPC_ASSERT_ALWAYS(a_reset_empty, clk, $rose(arst_n) |-> !m_tvalid, "output valid as reset releases")

endmodule

bind window_layer_pixel_compositor_core wlpc_checker u_wlpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
